[rtl/ltrs_pkg.sv]
// Shared widths, codes and controller/datapath interface types for the R squared block.
package ltrs_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned MAX_LEN  = 1024;
  localparam int unsigned CNT_W    = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W    = $clog2(MAX_LEN);
  localparam int unsigned SUM_W    = SAMPLE_W + CNT_W;
  localparam int unsigned SQ_W     = 2 * SAMPLE_W;
  localparam int unsigned SSQ_W    = SQ_W + CNT_W;
  localparam int unsigned KY_W     = SAMPLE_W + IDX_W + 1;
  localparam int unsigned SKY_W    = SAMPLE_W + IDX_W + CNT_W;
  localparam int unsigned VAR_W    = SSQ_W + CNT_W;
  localparam int unsigned N2_W     = 2 * CNT_W;
  localparam int unsigned A_W      = SKY_W + 2;
  localparam int unsigned MB_W     = A_W - 1;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned R_W      = FRAC_W + 1;
  localparam int unsigned QB       = FRAC_W + 2;
  localparam int unsigned QCNT_W   = $clog2(QB);
  localparam int unsigned WORK_W   = 2 * MB_W + 2 + FRAC_W;

  localparam logic [R_W-1:0] R_ONE = R_W'(1) << FRAC_W;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FLAT = 2'd2,
    ST_OVF  = 2'd3
  } status_e;

  // Multiply steps of the end-of-series sequence
  typedef enum logic [2:0] {
    OP_NSYY = 3'd0,  // n * Syy
    OP_SYSQ = 3'd1,  // Sy * Sy, gives variance term
    OP_N2   = 3'd2,  // n * n
    OP_DEN  = 3'd3,  // (n^2-1) * var
    OP_NSY  = 3'd4,  // (n-1) * |Sy|, gives a
    OP_A2   = 3'd5   // a * a, gives numerator
  } op_e;

  typedef struct packed {
    logic take;
    logic mul_start;
    logic mul_step;
    logic cap;
    op_e  op;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic var_zero;
    logic div_last;
    logic ovf;
    logic few;
    logic out_busy;
  } stat_t;

endpackage

[rtl/linear_trend_r_squared.sv]
// Top level of the linear trend R squared block: controller plus datapath.
//
// Takes one series of samples, one transfer per cycle while in_ready_o is
// high, each with a present flag and a last marker. Present samples get
// indices 0,1,2,... and feed a running count, sum, sum of squares and sum
// of index times sample (a 24x24 and an 11x24 product are registered, then
// added in the following cycle). A sample beyond the 1024th present one is
// dropped and flags overflow. The transfer carrying last starts the
// end-of-series work; in_ready_o stays low until the result is loaded: a
// settle state, then six products on a shared shift-add multiplier (n*Syy,
// Sy*Sy, n*n, (n^2-1)*var, (n-1)*|Sy|, a*a), each stepping through the
// significant bits of its multiplier operand (n, |Sy|, n, n^2-1, n-1, |a|),
// a variance check after Sy*Sy, then restoring division to an 18-bit
// quotient and a load of the result register. Status 1 or 3 results skip
// the multiplies and division, status 2 results skip all work after the
// variance check. The load waits while the previous result is still held
// in the output register and not being taken. Output is R squared in
// unsigned Q1.16, rounded down (0 when status is nonzero), with status 0
// ok, 1 fewer than two points, 2 zero variance, 3 overflow. The result sits
// in an output register, so the next series can stream in while a result
// waits for its transfer. State clears after each series.
module linear_trend_r_squared (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [ltrs_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 sample_valid_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [ltrs_pkg::R_W-1:0]      r_squared_o,
  output logic        [1:0]                    status_o
);
  import ltrs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing: accept, multiply chain, divide, result load
  ltrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // sums, multiplier, divider and output register
  ltrs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .out_ready_i    (out_ready_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .r_squared_o    (r_squared_o),
    .status_o       (status_o)
  );

endmodule

[rtl/ltrs_ctrl.sv]
// Sequencer for accumulation, the end-of-series multiply chain, division and result load.
module ltrs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           last_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  input  ltrs_pkg::stat_t stat_i,
  output ltrs_pkg::cmd_t  cmd_o
);
  import ltrs_pkg::*;

  localparam logic [2:0] S_ACC    = 3'd0;
  localparam logic [2:0] S_SETTLE = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_CHKVAR = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_q, state_d;
  op_e        op_q, op_d;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '0;
    cmd_o.op   = op_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_ACC: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && last_i) state_d = S_SETTLE;
      end
      S_SETTLE: begin
        // last sample lands in the sums during this cycle
        if (stat_i.ovf || stat_i.few) begin
          state_d = S_OUT;
        end else begin
          op_d    = OP_NSYY;
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_RUN;
      end
      S_RUN: begin
        if (!stat_i.mul_done) begin
          cmd_o.mul_step = 1'b1;
        end else begin
          cmd_o.cap = 1'b1;
          case (op_q)
            OP_NSYY: begin op_d = OP_SYSQ; state_d = S_START; end
            OP_SYSQ: state_d = S_CHKVAR;
            OP_N2:   begin op_d = OP_DEN;  state_d = S_START; end
            OP_DEN:  begin op_d = OP_NSY;  state_d = S_START; end
            OP_NSY:  begin op_d = OP_A2;   state_d = S_START; end
            OP_A2:   state_d = S_DIV;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_CHKVAR: begin
        if (stat_i.var_zero) begin
          state_d = S_OUT;
        end else begin
          op_d    = OP_N2;
          state_d = S_START;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_OUT;
      end
      S_OUT: begin
        if (!stat_i.out_busy || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      op_q    <= OP_NSYY;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

[rtl/ltrs_dp.sv]
// Datapath: running sums, shift-add multiplier, restoring divider and result register.
module ltrs_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [ltrs_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                  sample_valid_i,
  input  logic                                  out_ready_i,
  input  ltrs_pkg::cmd_t                        cmd_i,
  output ltrs_pkg::stat_t                       stat_o,
  output logic                                  out_valid_o,
  output logic        [ltrs_pkg::R_W-1:0]       r_squared_o,
  output logic        [1:0]                     status_o
);
  import ltrs_pkg::*;

  // accumulation
  logic        [CNT_W-1:0]  count_q;
  logic                     ovf_q;
  logic                     pipe_vld_q;
  logic signed [SAMPLE_W-1:0] y_q;
  logic        [SQ_W-1:0]   sq_q;
  logic signed [KY_W-1:0]   ky_q;
  logic signed [SUM_W-1:0]  sum_y_q;
  logic        [SSQ_W-1:0]  sum_sq_q;
  logic signed [SKY_W-1:0]  sum_ky_q;
  logic signed [SQ_W-1:0]   sq_s;
  logic signed [KY_W-1:0]   ky_s;
  logic                     room;

  assign room = count_q < CNT_W'(MAX_LEN);
  assign sq_s = sample_i * sample_i;
  assign ky_s = $signed({1'b0, count_q[IDX_W-1:0]}) * sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ovf_q      <= 1'b0;
      pipe_vld_q <= 1'b0;
      sum_y_q    <= '0;
      sum_sq_q   <= '0;
      sum_ky_q   <= '0;
    end else begin
      pipe_vld_q <= cmd_i.take && sample_valid_i && room;
      if (cmd_i.out_load) begin
        count_q  <= '0;
        ovf_q    <= 1'b0;
        sum_y_q  <= '0;
        sum_sq_q <= '0;
        sum_ky_q <= '0;
      end else begin
        if (cmd_i.take && sample_valid_i) begin
          if (room) count_q <= count_q + CNT_W'(1);
          else      ovf_q   <= 1'b1;
        end
        if (pipe_vld_q) begin
          sum_y_q  <= sum_y_q + SUM_W'(y_q);
          sum_sq_q <= sum_sq_q + SSQ_W'(sq_q);
          sum_ky_q <= sum_ky_q + SKY_W'(ky_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      y_q  <= sample_i;
      sq_q <= SQ_W'(unsigned'(sq_s));
      ky_q <= ky_s;
    end
  end

  // shared shift-add multiplier
  logic [WORK_W-1:0] p_q, a_q;
  logic [MB_W-1:0]   b_q;
  logic [WORK_W-1:0] op_a;
  logic [MB_W-1:0]   op_b;
  logic [SUM_W-1:0]  abs_sy;
  logic [MB_W-1:0]   abs_a;
  logic [VAR_W-1:0]  t_q, var_q;
  logic [N2_W-1:0]   n2m1_q;
  logic signed [A_W-1:0] lin_q;
  logic signed [A_W-1:0] two_sky, nsy_s, lin_d, lin_abs;

  assign abs_sy  = sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
  assign lin_abs = lin_q[A_W-1] ? -lin_q : lin_q;
  assign abs_a   = lin_abs[MB_W-1:0];
  assign two_sky = A_W'(sum_ky_q) <<< 1;
  assign nsy_s   = sum_y_q[SUM_W-1] ? -$signed(p_q[A_W-1:0]) : $signed(p_q[A_W-1:0]);
  assign lin_d   = two_sky - nsy_s;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.op)
      OP_NSYY: begin op_a = WORK_W'(sum_sq_q); op_b = MB_W'(count_q);  end
      OP_SYSQ: begin op_a = WORK_W'(abs_sy);   op_b = MB_W'(abs_sy);   end
      OP_N2:   begin op_a = WORK_W'(count_q);  op_b = MB_W'(count_q);  end
      OP_DEN:  begin op_a = WORK_W'(var_q);    op_b = MB_W'(n2m1_q);   end
      OP_NSY:  begin op_a = WORK_W'(abs_sy);   op_b = MB_W'(count_q - CNT_W'(1)); end
      OP_A2:   begin op_a = WORK_W'(abs_a);    op_b = abs_a;           end
      default: begin op_a = '0;                op_b = '0;              end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      p_q <= '0;
      a_q <= op_a;
      b_q <= op_b;
    end else if (cmd_i.mul_step) begin
      if (b_q[0]) p_q <= p_q + a_q;
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  // restoring divider, remainder starts as the numerator
  logic [WORK_W-1:0] rem_q, dsh_q;
  logic [QB-1:0]     q_q;
  logic [QCNT_W-1:0] dcnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      case (cmd_i.op)
        OP_NSYY: t_q    <= p_q[VAR_W-1:0];
        OP_SYSQ: var_q  <= t_q - p_q[VAR_W-1:0];
        OP_N2:   n2m1_q <= p_q[N2_W-1:0] - N2_W'(1);
        OP_DEN:  dsh_q  <= p_q << (FRAC_W + 1);
        OP_NSY:  lin_q  <= lin_d;
        OP_A2: begin
          rem_q  <= (p_q + (p_q << 1)) << FRAC_W;
          q_q    <= '0;
          dcnt_q <= QCNT_W'(QB - 1);
        end
        default: t_q <= t_q;
      endcase
    end else if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        q_q   <= {q_q[QB-2:0], 1'b1};
      end else begin
        q_q   <= {q_q[QB-2:0], 1'b0};
      end
      dsh_q  <= dsh_q >> 1;
      dcnt_q <= dcnt_q - QCNT_W'(1);
    end
  end

  // result register
  logic             out_valid_q;
  logic [R_W-1:0]   r_q;
  status_e          st_q, st_d;
  logic [R_W-1:0]   r_sat;

  assign r_sat = (q_q > QB'(R_ONE)) ? R_ONE : q_q[R_W-1:0];

  always_comb begin
    if (ovf_q)                st_d = ST_OVF;
    else if (count_q < CNT_W'(2)) st_d = ST_FEW;
    else if (var_q == '0)     st_d = ST_FLAT;
    else                      st_d = ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      st_q <= st_d;
      r_q  <= (st_d == ST_OK) ? r_sat : '0;
    end
  end

  assign stat_o.mul_done = (b_q == '0);
  assign stat_o.var_zero = (var_q == '0);
  assign stat_o.div_last = (dcnt_q == '0);
  assign stat_o.ovf      = ovf_q;
  assign stat_o.few      = count_q < CNT_W'(2);
  assign stat_o.out_busy = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign r_squared_o = r_q;
  assign status_o    = st_q;

endmodule
